// ----- design/cso_pkg.sv -----
// ----------------------------------------------------------------------------
// Collinear segment overlap splitter package
// Shared command type and fixed constants for the splitter front, queue and back.
// ----------------------------------------------------------------------------
`default_nettype none

package cso_pkg;

   // Actions for one accepted item, carried from the front to the back.
   typedef struct packed {
      logic flush_before;  // close and emit the cluster that is open
      logic open_new;      // this segment starts a new cluster
      logic flush_after;   // final item: close and emit after adding
   } cmd_ctl_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = 2;
   localparam int PCS_BITS    = 6;
   localparam logic [PCS_BITS-1:0] PIECE_CAP = 6'd63;
   localparam int SUM_BITS    = 32;

endpackage

`default_nettype wire

// ----- design/cso_front.sv -----
// ----------------------------------------------------------------------------
// Splitter front
// Accepts segments, orders their ends and decides whether each one joins the
// open cluster, closes it, or is the final item.
// ----------------------------------------------------------------------------
`default_nettype none

module cso_front #(
   parameter int CB = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_orient,
   input  wire logic [CB-1:0]        req_line,
   input  wire logic [CB-1:0]        req_lo,
   input  wire logic [CB-1:0]        req_hi,
   input  wire logic                 req_final_item,
   input  wire logic                 q_full,
   output logic                      q_push,
   output cso_pkg::cmd_ctl_type      cmd_ctl,
   output logic                      cmd_orient,
   output logic [CB-1:0]             cmd_line,
   output logic [CB-1:0]             cmd_a,
   output logic [CB-1:0]             cmd_b
);
   import cso_pkg::*;

   logic          open_ff, open_in;
   logic          orient_ff, orient_in;
   logic [CB-1:0] line_ff, line_in;
   logic [CB:0]   reach_ff, reach_in;
   logic [CB-1:0] a, b;
   logic [CB:0]   a_ext, b_ext, a_inc;
   logic          same, join_cl;

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   always_comb begin
      a = (req_lo > req_hi) ? req_hi : req_lo;
      b = (req_lo > req_hi) ? req_lo : req_hi;
      a_ext = {1'b0, a};
      b_ext = {1'b0, b};
      a_inc = a_ext + {{CB{1'b0}}, 1'b1};
      same    = open_ff && (req_orient == orient_ff) && (req_line == line_ff);
      join_cl = same && (reach_ff > a_ext);

      cmd_ctl.flush_before = open_ff && !join_cl;
      cmd_ctl.open_new     = !join_cl;
      cmd_ctl.flush_after  = req_final_item;
      cmd_orient = req_orient;
      cmd_line   = req_line;
      cmd_a      = a;
      cmd_b      = b;

      open_in   = open_ff;
      orient_in = orient_ff;
      line_in   = line_ff;
      reach_in  = reach_ff;
      if (q_push) begin
         if (join_cl) begin
            if (b_ext > reach_ff) begin
               reach_in = b_ext;
            end
         end else begin
            orient_in = req_orient;
            line_in   = req_line;
            if (same) begin
               reach_in = b_ext;
            end else begin
               reach_in = (a_inc > b_ext) ? a_inc : b_ext;
            end
         end
         open_in = !req_final_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff   <= 1'b0;
         orient_ff <= 1'b0;
         line_ff   <= '0;
         reach_ff  <= '0;
      end else begin
         open_ff   <= open_in;
         orient_ff <= orient_in;
         line_ff   <= line_in;
         reach_ff  <= reach_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/cso_cmd_queue.sv -----
// ----------------------------------------------------------------------------
// Splitter command queue
// Short first-in first-out queue that decouples the front from the back.
// ----------------------------------------------------------------------------
`default_nettype none

module cso_cmd_queue #(
   parameter int WIDTH = 52
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  full,
   output logic                  empty
);
   import cso_pkg::*;

   logic [WIDTH-1:0]     slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [QPTR_BITS:0]   cnt_ff, cnt_in;

   assign full     = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = slot_ff[rptr_ff];

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

endmodule

`default_nettype wire

// ----- design/cso_back.sv -----
// ----------------------------------------------------------------------------
// Splitter back
// Stores cluster endpoints, walks them in ascending order on a flush and
// emits one piece per pair of distinct neighbors through a two-entry output.
// ----------------------------------------------------------------------------
`default_nettype none

module cso_back #(
   parameter int CB   = 16,
   parameter int MAXC = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 cmd_valid,
   output logic                      cmd_pop,
   input  wire cso_pkg::cmd_ctl_type cmd_ctl,
   input  wire logic                 cmd_orient,
   input  wire logic [CB-1:0]        cmd_line,
   input  wire logic [CB-1:0]        cmd_a,
   input  wire logic [CB-1:0]        cmd_b,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic                      rsp_out_orient,
   output logic [CB-1:0]             rsp_out_line,
   output logic [CB-1:0]             rsp_out_lo,
   output logic [CB-1:0]             rsp_out_hi,
   output logic [31:0]               rsp_total_length,
   output logic                      rsp_cluster_overflow,
   output logic                      rsp_last_of_run
);
   import cso_pkg::*;

   localparam int DEPTH = 2 * MAXC;
   localparam int IW    = $clog2(DEPTH);
   localparam int RW    = IW + 1;
   localparam int CW    = $clog2(MAXC + 1);

   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_ADD_A  = 3'd1;
   localparam logic [2:0] ST_ADD_B  = 3'd2;
   localparam logic [2:0] ST_SCAN   = 3'd3;
   localparam logic [2:0] ST_DECIDE = 3'd4;
   localparam logic [2:0] ST_EMIT   = 3'd5;
   localparam logic [2:0] ST_DONE   = 3'd6;

   // Endpoint memory: one write and one registered read per cycle.
   logic [CB-1:0] mem [DEPTH];
   logic [CB-1:0] mem_q;
   logic          we, re;
   logic [IW-1:0] waddr, raddr;
   logic [CB-1:0] wdata;

   logic [2:0]    state_ff, state_in;
   cmd_ctl_type   ctl_ff, ctl_in;
   logic          c_orient_ff, c_orient_in;
   logic [CB-1:0] c_line_ff, c_line_in, c_a_ff, c_a_in, c_b_ff, c_b_in;
   logic          cl_orient_ff, cl_orient_in;
   logic [CB-1:0] cl_line_ff, cl_line_in;
   logic [CW-1:0] count_ff, count_in, eff_count;
   logic          ovf_ff, ovf_in;
   logic          phase_ff, phase_in;
   logic [RW-1:0] rd_idx_ff, rd_idx_in, scan_len;
   logic          pend_ff, pend_in, found_ff, found_in;
   logic [CB-1:0] best_ff, best_in, cur_ff, cur_in;
   logic          have_cur_ff, have_cur_in, cl_emit_ff, cl_emit_in;
   logic          more_ff, more_in;
   logic [CB-1:0] pc_a_ff, pc_a_in, pc_b_ff, pc_b_in;
   logic [PCS_BITS-1:0] pcs_ff, pcs_in;
   logic [SUM_BITS-1:0] sum_ff, sum_in, sum_next;
   logic          hv_ff, hv_in, h_orient_ff, h_orient_in, h_ovf_ff, h_ovf_in;
   logic [CB-1:0] h_line_ff, h_line_in, h_lo_ff, h_lo_in, h_hi_ff, h_hi_in;
   logic [SUM_BITS-1:0] h_sum_ff, h_sum_in;
   logic          rv_ff, rv_in, r_orient_ff, r_orient_in, r_ovf_ff, r_ovf_in;
   logic          r_last_ff, r_last_in;
   logic [CB-1:0] r_line_ff, r_line_in, r_lo_ff, r_lo_in, r_hi_ff, r_hi_in;
   logic [SUM_BITS-1:0] r_sum_ff, r_sum_in;
   logic          out_free, issue;

   assign rsp_valid            = rv_ff;
   assign rsp_out_orient       = r_orient_ff;
   assign rsp_out_line         = r_line_ff;
   assign rsp_out_lo           = r_lo_ff;
   assign rsp_out_hi           = r_hi_ff;
   assign rsp_total_length     = r_sum_ff;
   assign rsp_cluster_overflow = r_ovf_ff;
   assign rsp_last_of_run      = r_last_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         mem_q <= mem[raddr];
      end
   end

   always_comb begin
      state_in = state_ff;   ctl_in = ctl_ff;
      c_orient_in = c_orient_ff; c_line_in = c_line_ff;
      c_a_in = c_a_ff;       c_b_in = c_b_ff;
      cl_orient_in = cl_orient_ff; cl_line_in = cl_line_ff;
      count_in = count_ff;   ovf_in = ovf_ff;   phase_in = phase_ff;
      rd_idx_in = rd_idx_ff; pend_in = pend_ff; found_in = found_ff;
      best_in = best_ff;     cur_in = cur_ff;   have_cur_in = have_cur_ff;
      cl_emit_in = cl_emit_ff; more_in = more_ff;
      pc_a_in = pc_a_ff;     pc_b_in = pc_b_ff; pcs_in = pcs_ff; sum_in = sum_ff;
      hv_in = hv_ff; h_orient_in = h_orient_ff; h_ovf_in = h_ovf_ff;
      h_line_in = h_line_ff; h_lo_in = h_lo_ff; h_hi_in = h_hi_ff; h_sum_in = h_sum_ff;
      rv_in = rv_ff; r_orient_in = r_orient_ff; r_ovf_in = r_ovf_ff;
      r_last_in = r_last_ff; r_line_in = r_line_ff; r_lo_in = r_lo_ff;
      r_hi_in = r_hi_ff; r_sum_in = r_sum_ff;
      cmd_pop = 1'b0;
      we = 1'b0; re = 1'b0; waddr = '0; raddr = '0; wdata = c_a_ff;
      out_free  = !rv_ff || rsp_ready;
      eff_count = ctl_ff.open_new ? '0 : count_ff;
      scan_len  = RW'({count_ff, 1'b0});
      issue     = (rd_idx_ff != scan_len);
      sum_next  = sum_ff + SUM_BITS'(pc_b_ff - pc_a_ff);

      if (rv_ff && rsp_ready) begin
         rv_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               ctl_in = cmd_ctl; c_orient_in = cmd_orient; c_line_in = cmd_line;
               c_a_in = cmd_a;   c_b_in = cmd_b;
               pcs_in = '0;
               if (cmd_ctl.flush_before) begin
                  phase_in = 1'b0; have_cur_in = 1'b0; cl_emit_in = 1'b0;
                  found_in = 1'b0; rd_idx_in = '0; pend_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_ADD_A;
               end
            end
         end
         ST_ADD_A: begin
            if (ctl_ff.open_new) begin
               cl_orient_in = c_orient_ff; cl_line_in = c_line_ff; ovf_in = 1'b0;
            end
            count_in = eff_count;
            if (eff_count < CW'(MAXC)) begin
               we = 1'b1; waddr = IW'({eff_count, 1'b0}); wdata = c_a_ff;
               state_in = ST_ADD_B;
            end else begin
               ovf_in = 1'b1;
               if (ctl_ff.flush_after) begin
                  phase_in = 1'b1; have_cur_in = 1'b0; cl_emit_in = 1'b0;
                  found_in = 1'b0; rd_idx_in = '0; pend_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ADD_B: begin
            we = 1'b1; waddr = IW'({count_ff, 1'b1}); wdata = c_b_ff;
            count_in = count_ff + 1'b1;
            if (ctl_ff.flush_after) begin
               phase_in = 1'b1; have_cur_in = 1'b0; cl_emit_in = 1'b0;
               found_in = 1'b0; rd_idx_in = '0; pend_in = 1'b0;
               state_in = ST_SCAN;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SCAN: begin
            // Find the smallest stored end above the current one.
            re = issue;
            raddr = rd_idx_ff[IW-1:0];
            pend_in = issue;
            if (issue) begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
            if (pend_ff && (!have_cur_ff || mem_q > cur_ff)
                && (!found_ff || mem_q < best_ff)) begin
               best_in = mem_q; found_in = 1'b1;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (found_ff) begin
               cur_in = best_ff; have_cur_in = 1'b1;
               if (have_cur_ff) begin
                  pc_a_in = cur_ff; pc_b_in = best_ff; cl_emit_in = 1'b1;
                  more_in = 1'b1; state_in = ST_EMIT;
               end else begin
                  found_in = 1'b0; rd_idx_in = '0; pend_in = 1'b0;
                  state_in = ST_SCAN;
               end
            end else if (count_ff == CW'(1) && !cl_emit_ff) begin
               // A lone point segment is emitted as a zero-length piece.
               pc_a_in = cur_ff; pc_b_in = cur_ff; more_in = 1'b0;
               state_in = ST_EMIT;
            end else begin
               state_in = phase_ff ? ST_DONE : ST_ADD_A;
            end
         end
         ST_EMIT: begin
            if (pcs_ff == PIECE_CAP || !hv_ff || out_free) begin
               if (pcs_ff != PIECE_CAP) begin
                  if (hv_ff) begin
                     rv_in = 1'b1; r_orient_in = h_orient_ff; r_line_in = h_line_ff;
                     r_lo_in = h_lo_ff; r_hi_in = h_hi_ff; r_sum_in = h_sum_ff;
                     r_ovf_in = h_ovf_ff; r_last_in = 1'b0;
                  end
                  hv_in = 1'b1; h_orient_in = cl_orient_ff; h_line_in = cl_line_ff;
                  h_lo_in = pc_a_ff; h_hi_in = pc_b_ff; h_sum_in = sum_next;
                  h_ovf_in = ovf_ff;
                  sum_in = sum_next; pcs_in = pcs_ff + 1'b1;
               end
               if (more_ff) begin
                  found_in = 1'b0; rd_idx_in = '0; pend_in = 1'b0;
                  state_in = ST_SCAN;
               end else begin
                  state_in = phase_ff ? ST_DONE : ST_ADD_A;
               end
            end
         end
         ST_DONE: begin
            if (!hv_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               rv_in = 1'b1; r_orient_in = h_orient_ff; r_line_in = h_line_ff;
               r_lo_in = h_lo_ff; r_hi_in = h_hi_ff; r_sum_in = h_sum_ff;
               r_ovf_in = h_ovf_ff; r_last_in = 1'b1;
               hv_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         ovf_ff   <= 1'b0;
         sum_ff   <= '0;
         hv_ff    <= 1'b0;
         rv_ff    <= 1'b0;
         pend_ff  <= 1'b0;
         cl_orient_ff <= 1'b0;
         cl_line_ff   <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         sum_ff   <= sum_in;
         hv_ff    <= hv_in;
         rv_ff    <= rv_in;
         pend_ff  <= pend_in;
         cl_orient_ff <= cl_orient_in;
         cl_line_ff   <= cl_line_in;
      end
   end

   always_ff @(posedge clock) begin
      ctl_ff <= ctl_in; c_orient_ff <= c_orient_in; c_line_ff <= c_line_in;
      c_a_ff <= c_a_in; c_b_ff <= c_b_in; phase_ff <= phase_in;
      rd_idx_ff <= rd_idx_in; found_ff <= found_in; best_ff <= best_in;
      cur_ff <= cur_in; have_cur_ff <= have_cur_in; cl_emit_ff <= cl_emit_in;
      more_ff <= more_in; pc_a_ff <= pc_a_in; pc_b_ff <= pc_b_in; pcs_ff <= pcs_in;
      h_orient_ff <= h_orient_in; h_ovf_ff <= h_ovf_in; h_line_ff <= h_line_in;
      h_lo_ff <= h_lo_in; h_hi_ff <= h_hi_in; h_sum_ff <= h_sum_in;
      r_orient_ff <= r_orient_in; r_ovf_ff <= r_ovf_in; r_last_ff <= r_last_in;
      r_line_ff <= r_line_in; r_lo_ff <= r_lo_in; r_hi_ff <= r_hi_in;
      r_sum_ff <= r_sum_in;
   end

endmodule

`default_nettype wire

// ----- design/collinear_segment_overlap_splitter.sv -----
// ----------------------------------------------------------------------------
// Collinear segment overlap splitter
// Merges overlapping collinear wire segments into clusters and splits each
// cluster into non-overlapping pieces with a running total length.
// In the back an added item passes the idle, add-A, add-B and done states.
// A flush rescans the 2*N stored ends through the single read port of the
// endpoint memory to find each distinct end in turn, and emits each piece as
// it is found, held by any output stall.
// The front accepts one item per cycle while the 4-entry queue has room.
// Reset (synchronous, active high) closes the cluster, clears the length sum
// and empties the queue and output registers; the endpoint memory is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module collinear_segment_overlap_splitter #(
   parameter int COORD_BITS  = 16,
   parameter int MAX_CLUSTER = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire logic                  req_orient,
   input  wire logic [COORD_BITS-1:0] req_line,
   input  wire logic [COORD_BITS-1:0] req_lo,
   input  wire logic [COORD_BITS-1:0] req_hi,
   input  wire logic                  req_final_item,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output logic                       rsp_out_orient,
   output logic [COORD_BITS-1:0]      rsp_out_line,
   output logic [COORD_BITS-1:0]      rsp_out_lo,
   output logic [COORD_BITS-1:0]      rsp_out_hi,
   output logic [31:0]                rsp_total_length,
   output logic                       rsp_cluster_overflow,
   output logic                       rsp_last_of_run
);
   import cso_pkg::*;

   localparam int CTL_BITS = $bits(cmd_ctl_type);
   localparam int QW       = CTL_BITS + 1 + 3 * COORD_BITS;

   // Front side of the queue: the classified item.
   cmd_ctl_type           f_ctl;
   logic                  f_orient;
   logic [COORD_BITS-1:0] f_line, f_a, f_b;
   logic                  q_push, q_pop, q_full, q_empty;
   logic [QW-1:0]         q_wdata, q_rdata;

   // Back side of the queue.
   cmd_ctl_type           b_ctl;
   logic                  b_orient;
   logic [COORD_BITS-1:0] b_line, b_a, b_b;

   assign q_wdata = {f_ctl, f_orient, f_line, f_a, f_b};
   assign {b_ctl, b_orient, b_line, b_a, b_b} = q_rdata;

   // The front decides join or split for each item and tracks the reach.
   cso_front #(.CB(COORD_BITS)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_orient     (req_orient),
      .req_line       (req_line),
      .req_lo         (req_lo),
      .req_hi         (req_hi),
      .req_final_item (req_final_item),
      .q_full         (q_full),
      .q_push         (q_push),
      .cmd_ctl        (f_ctl),
      .cmd_orient     (f_orient),
      .cmd_line       (f_line),
      .cmd_a          (f_a),
      .cmd_b          (f_b)
   );

   cso_cmd_queue #(.WIDTH(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .full      (q_full),
      .empty     (q_empty)
   );

   // The back stores the ends and produces the pieces in ascending order.
   cso_back #(.CB(COORD_BITS), .MAXC(MAX_CLUSTER)) u_back (
      .clock                (clock),
      .reset                (reset),
      .cmd_valid            (!q_empty),
      .cmd_pop              (q_pop),
      .cmd_ctl              (b_ctl),
      .cmd_orient           (b_orient),
      .cmd_line             (b_line),
      .cmd_a                (b_a),
      .cmd_b                (b_b),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_out_orient       (rsp_out_orient),
      .rsp_out_line         (rsp_out_line),
      .rsp_out_lo           (rsp_out_lo),
      .rsp_out_hi           (rsp_out_hi),
      .rsp_total_length     (rsp_total_length),
      .rsp_cluster_overflow (rsp_cluster_overflow),
      .rsp_last_of_run      (rsp_last_of_run)
   );

   // A piece never runs backward.
   a_piece_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_out_lo <= rsp_out_hi))
      else $error("piece with lo above hi");

   // The back only takes an item from a queue that holds one.
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("queue popped while empty");

   // No piece is shown in the first cycle after reset is released.
   a_reset_quiet: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid after reset");

endmodule

`default_nettype wire

// ----- bench/tb_collinear_segment_overlap_splitter.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the collinear segment overlap splitter
// Feeds sorted runs of wire segments with random content plus some noise,
// predicts every emitted piece in a cycle-free model of the clustering, and
// compares each accepted piece with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_collinear_segment_overlap_splitter;
   import cso_pkg::*;

   localparam int CLK_HALF    = 4;
   localparam int CYCLE_LIMIT = 1000000;
   localparam int CLUSTER_CAP = 32;
   localparam int PIECE_LIMIT = 63;
   localparam int ITEM_TARGET = 220;

   typedef struct packed {
      logic        orient;
      logic [15:0] line;
      logic [15:0] lo;
      logic [15:0] hi;
      logic        fin;
   } segment_type;

   typedef struct packed {
      logic        orient;
      logic [15:0] line;
      logic [15:0] lo;
      logic [15:0] hi;
      logic [31:0] total;
      logic        ovf;
      logic        last;
   } piece_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic        req_orient = 1'b0;
   logic [15:0] req_line = '0;
   logic [15:0] req_lo = '0;
   logic [15:0] req_hi = '0;
   logic        req_final_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic        rsp_out_orient;
   logic [15:0] rsp_out_line;
   logic [15:0] rsp_out_lo;
   logic [15:0] rsp_out_hi;
   logic [31:0] rsp_total_length;
   logic        rsp_cluster_overflow;
   logic        rsp_last_of_run;

   collinear_segment_overlap_splitter #(
      .COORD_BITS(16),
      .MAX_CLUSTER(CLUSTER_CAP)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_orient(req_orient),
      .req_line(req_line),
      .req_lo(req_lo),
      .req_hi(req_hi),
      .req_final_item(req_final_item),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_orient(rsp_out_orient),
      .rsp_out_line(rsp_out_line),
      .rsp_out_lo(rsp_out_lo),
      .rsp_out_hi(rsp_out_hi),
      .rsp_total_length(rsp_total_length),
      .rsp_cluster_overflow(rsp_cluster_overflow),
      .rsp_last_of_run(rsp_last_of_run)
   );

   initial begin
      forever #CLK_HALF clock = ~clock;
   end

   // Segments waiting to be driven, and pieces waiting to come out.
   segment_type pending_segments[$];
   piece_type   expected_pieces[$];
   piece_type   step_pieces[$];

   int errors = 0;
   int cycle_count = 0;
   int accepted_items = 0;

   // Model of the clustering state.
   logic        cl_open = 1'b0;
   logic        cl_orient = 1'b0;
   logic [15:0] cl_line = '0;
   logic [16:0] cl_reach = '0;
   logic [15:0] cl_ends[64];
   int          cl_count = 0;
   logic        cl_ovf = 1'b0;
   logic [31:0] length_sum = '0;

   // A step emits at most 63 pieces; anything beyond is lost and not summed.
   function automatic void emit_piece(logic [15:0] a, logic [15:0] b);
      piece_type p;
      if (step_pieces.size() >= PIECE_LIMIT) return;
      length_sum = length_sum + 32'(b - a);
      p.orient = cl_orient;
      p.line   = cl_line;
      p.lo     = a;
      p.hi     = b;
      p.total  = length_sum;
      p.ovf    = cl_ovf;
      p.last   = 1'b0;
      step_pieces = {step_pieces, p};
   endfunction

   function automatic void close_cluster();
      logic [15:0] pts[$];
      int n;
      if (!cl_open) return;
      n = cl_count;
      if (n == 1) begin
         emit_piece(cl_ends[0], cl_ends[1]);
      end else if (n > 1) begin
         for (int i = 0; i < 2 * n; i++) pts = {pts, cl_ends[i]};
         pts.sort();
         for (int i = 0; i + 1 < 2 * n; i++)
            if (pts[i] != pts[i + 1]) emit_piece(pts[i], pts[i + 1]);
      end
      cl_open = 1'b0;
   endfunction

   // Segments past the capacity still stretch the reach but are not stored.
   function automatic void store_segment(logic [15:0] a, logic [15:0] b);
      if (cl_count < CLUSTER_CAP) begin
         cl_ends[2 * cl_count]     = a;
         cl_ends[2 * cl_count + 1] = b;
         cl_count++;
      end else begin
         cl_ovf = 1'b1;
      end
   endfunction

   function automatic void start_cluster(logic o, logic [15:0] ln, logic [15:0] a,
                                         logic [15:0] b, logic [16:0] reach);
      cl_open   = 1'b1;
      cl_orient = o;
      cl_line   = ln;
      cl_reach  = reach;
      cl_count  = 0;
      cl_ovf    = 1'b0;
      store_segment(a, b);
   endfunction

   function automatic void predict_pieces(segment_type s);
      logic [15:0] a, b;
      logic [16:0] first_reach;
      a = (s.lo > s.hi) ? s.hi : s.lo;
      b = (s.lo > s.hi) ? s.lo : s.hi;
      step_pieces.delete();
      if (cl_open && s.orient == cl_orient && s.line == cl_line) begin
         if (cl_reach > {1'b0, a}) begin
            if ({1'b0, b} > cl_reach) cl_reach = {1'b0, b};
            store_segment(a, b);
         end else begin
            // Touching the reach ends the cluster; the new reach is just hi.
            close_cluster();
            start_cluster(s.orient, s.line, a, b, {1'b0, b});
         end
      end else begin
         // First segment on a line: a point still leaves room for equal lo.
         close_cluster();
         first_reach = ({1'b0, a} + 17'd1 > {1'b0, b}) ? {1'b0, a} + 17'd1 : {1'b0, b};
         start_cluster(s.orient, s.line, a, b, first_reach);
      end
      if (s.fin) close_cluster();
      if (step_pieces.size() > 0) step_pieces[step_pieces.size() - 1].last = 1'b1;
      foreach (step_pieces[i]) expected_pieces = {expected_pieces, step_pieces[i]};
   endfunction

   function automatic void add_segment_item(logic o, logic [15:0] ln, logic [15:0] lo,
                                            logic [15:0] hi, logic fin);
      segment_type s;
      s.orient = o;
      s.line   = ln;
      s.lo     = lo;
      s.hi     = hi;
      s.fin    = fin;
      pending_segments = {pending_segments, s};
   endfunction

   // A run of sorted, mostly overlapping segments on one line.
   function automatic void add_random_run();
      logic        o;
      logic [15:0] ln;
      int          pos, len, n;
      o   = 1'($urandom);
      ln  = ($urandom_range(0, 7) == 0) ? 16'hFFFF : 16'($urandom);
      pos = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(0, 65535);
      n   = $urandom_range(1, 6);
      for (int i = 0; i < n; i++) begin
         len = ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 40);
         if (pos + len > 65535) len = 65535 - pos;
         if ($urandom_range(0, 9) == 0)
            add_segment_item(o, ln, 16'(pos + len), 16'(pos), 1'b0);
         else
            add_segment_item(o, ln, 16'(pos), 16'(pos + len), 1'b0);
         pos = pos + $urandom_range(0, (len > 0) ? len : 1);
         if (pos > 65535) pos = 65535;
      end
      if ($urandom_range(0, 3) == 0)
         pending_segments[pending_segments.size() - 1].fin = 1'b1;
   endfunction

   initial begin
      // Directed part: extremes, points, touching breaks, reversed ends.
      add_segment_item(1'b0, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
      add_segment_item(1'b0, 16'h0000, 16'h0010, 16'h0020, 1'b1);
      add_segment_item(1'b1, 16'hFFFF, 16'h0005, 16'h0005, 1'b0);
      add_segment_item(1'b1, 16'hFFFF, 16'h0005, 16'h0009, 1'b0);
      add_segment_item(1'b1, 16'hFFFF, 16'h0009, 16'h000C, 1'b0);
      add_segment_item(1'b1, 16'hFFFF, 16'h000B, 16'h000B, 1'b0);
      add_segment_item(1'b0, 16'hFFFF, 16'h0030, 16'h0020, 1'b0);
      add_segment_item(1'b0, 16'hFFFF, 16'h0025, 16'h0040, 1'b0);
      add_segment_item(1'b0, 16'hFFFF, 16'h0028, 16'h0030, 1'b0);
      add_segment_item(1'b0, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0);
      add_segment_item(1'b0, 16'h1234, 16'hFFFF, 16'hFFFF, 1'b0);
      add_segment_item(1'b1, 16'h5555, 16'hFFF0, 16'hFFFF, 1'b0);
      add_segment_item(1'b1, 16'h5555, 16'h0003, 16'h0008, 1'b0);
      add_segment_item(1'b1, 16'hAAAA, 16'h0000, 16'h0000, 1'b1);
      add_segment_item(1'b1, 16'hAAAA, 16'h0000, 16'h0000, 1'b1);
      add_segment_item(1'b0, 16'h0001, 16'h0100, 16'h0200, 1'b0);
      add_segment_item(1'b0, 16'h0001, 16'h0100, 16'h0200, 1'b1);

      // Random part, with one overfull cluster and one cluster of 63 pieces.
      while (pending_segments.size() < ITEM_TARGET) begin
         if (pending_segments.size() > 60 && pending_segments.size() < 70) begin
            for (int i = 0; i < 35; i++)
               add_segment_item(1'b1, 16'h0777, 16'(i * 3), 16'(i * 3 + 5), 1'b0);
         end else if (pending_segments.size() > 130 && pending_segments.size() < 140) begin
            // Nested segments with all ends distinct; the final item on
            // another line would be the 64th piece and is dropped.
            for (int i = 0; i < CLUSTER_CAP; i++)
               add_segment_item(1'b0, 16'h4321, 16'(i), 16'(1000 - i), 1'b0);
            add_segment_item(1'b0, 16'h4322, 16'h0001, 16'h0002, 1'b1);
         end else if ($urandom_range(0, 9) == 0) begin
            add_segment_item(1'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                             1'($urandom_range(0, 3) == 0));
         end else begin
            add_random_run();
         end
      end
      pending_segments[pending_segments.size() - 1].fin = 1'b1;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Drain: everything sent, every prediction matched, then a short tail.
      while (pending_segments.size() > 0 || req_valid || expected_pieces.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0)
         $display("tb_collinear_segment_overlap_splitter: PASS");
      else
         $display("tb_collinear_segment_overlap_splitter: FAIL");
      $finish;
   end

   // Sender: bursts of random length separated by random gaps.
   logic item_taken = 1'b0;
   int   burst_left = 4;
   int   gap_left = 0;

   always @(negedge clock) begin
      if (!reset && !(req_valid && !item_taken)) begin
         if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_segments.size() > 0) begin
            req_valid      <= 1'b1;
            req_orient     <= pending_segments[0].orient;
            req_line       <= pending_segments[0].line;
            req_lo         <= pending_segments[0].lo;
            req_hi         <= pending_segments[0].hi;
            req_final_item <= pending_segments[0].fin;
            void'(pending_segments.pop_front());
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 12);
               gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls in some stretches, none in others, and one long
   // hold-off so the queue fills and the input side backs up.
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  phase_cycles = 0;
   bit  stall_phase = 1'b1;

   always @(negedge clock) begin
      if (!reset) begin
         if (!hold_done && accepted_items >= 40) begin
            hold_done <= 1'b1;
            hold_left <= 400;
            rsp_ready <= 1'b0;
         end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_ready <= 1'b0;
         end else begin
            if (phase_cycles >= 300) begin
               phase_cycles <= 0;
               stall_phase  <= ~stall_phase;
            end else begin
               phase_cycles <= phase_cycles + 1;
            end
            rsp_ready <= stall_phase ? ($urandom_range(0, 3) != 0) : 1'b1;
         end
      end
   end

   // Monitor: predict on every accepted item, check every accepted piece.
   piece_type seen;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_collinear_segment_overlap_splitter: FAIL");
         $finish;
      end
      item_taken <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready) begin
         accepted_items <= accepted_items + 1;
         predict_pieces({req_orient, req_line, req_lo, req_hi, req_final_item});
      end
      if (!reset && rsp_valid && rsp_ready) begin
         seen = {rsp_out_orient, rsp_out_line, rsp_out_lo, rsp_out_hi, rsp_total_length,
                 rsp_cluster_overflow, rsp_last_of_run};
         if (expected_pieces.size() == 0) begin
            errors = errors + 1;
            if (errors <= 10) $display("unexpected piece %p", seen);
         end else begin
            if (seen !== expected_pieces[0]) begin
               errors = errors + 1;
               if (errors <= 10)
                  $display("piece mismatch: expected %p, got %p", expected_pieces[0], seen);
            end
            void'(expected_pieces.pop_front());
         end
      end
   end

endmodule
